FILE: hdl/bsfe_pkg.sv
`default_nettype none

package bsfe_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h1021;

  // One classified body word on its way from the front end to the emitter.
  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [15:0] crc;
  } entry_t;

  // Fold one byte into a CRC-16, MSB first.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic needs_escape(input logic [7:0] b);
    return (b == FLAG_BYTE) || (b == ESC_BYTE);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/bsfe_if.sv
`default_nettype none

interface bsfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                  output ready);
endinterface

interface bsfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       run_last;

  modport source (output valid, output line_byte, output run_last, input ready);
  modport sink   (input valid, input line_byte, input run_last, output ready);
endinterface

`default_nettype wire

FILE: hdl/bsfe_queue.sv
`default_nettype none

module bsfe_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire bsfe_pkg::entry_t push_entry,
  output logic                  not_full,
  input  wire logic             pop,
  output logic                  head_valid,
  output bsfe_pkg::entry_t      head_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bsfe_pkg::entry_t mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign not_full   = (count_r != CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count exceeds depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == CW'($past(count_r) + 1'b1)))
    else $error("queue count did not advance on push");

endmodule

`default_nettype wire

FILE: hdl/bsfe_front.sv
`default_nettype none

module bsfe_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  bsfe_in_if.sink          in_if,
  input  wire logic        q_not_full,
  output logic             push,
  output bsfe_pkg::entry_t push_entry
);

  logic [15:0] crc_r, crc_nxt;
  logic [15:0] crc_base;
  logic [15:0] crc_new;

  assign in_if.ready = q_not_full;
  assign push        = in_if.valid && q_not_full;

  // Restart the CRC on an opening word, fold the word in.
  assign crc_base = in_if.first_byte ? bsfe_pkg::CRC_INIT : crc_r;
  assign crc_new  = bsfe_pkg::crc_fold(crc_base, in_if.data_byte);

  always_comb begin
    crc_nxt = crc_r;
    if (push) begin
      crc_nxt = in_if.last_byte ? bsfe_pkg::CRC_INIT : crc_new;
    end
  end

  always_comb begin
    push_entry.data  = in_if.data_byte;
    push_entry.first = in_if.first_byte;
    push_entry.last  = in_if.last_byte;
    push_entry.crc   = crc_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= bsfe_pkg::CRC_INIT;
    end else begin
      crc_r <= crc_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bsfe_back.sv
`default_nettype none

module bsfe_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire bsfe_pkg::entry_t q_head,
  output logic                  q_pop,
  bsfe_out_if.source            out_if
);

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_OPEN   = 6'b000010,
    PH_DATA   = 6'b000100,
    PH_CRC_LO = 6'b001000,
    PH_CRC_HI = 6'b010000,
    PH_CLOSE  = 6'b100000
  } phase_t;

  phase_t           phase_r, phase_nxt;
  phase_t           phase_after;
  bsfe_pkg::entry_t cur_r;
  logic             esc_r, esc_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;

  logic       adv;
  logic       emit;
  logic       stuffed;
  logic       step_done;
  logic       finish;
  logic [7:0] cur_byte;
  logic [7:0] emit_byte;

  assign adv  = !out_valid_r || out_if.ready;
  assign emit = adv && (phase_r != PH_IDLE);

  always_comb begin
    cur_byte    = bsfe_pkg::FLAG_BYTE;
    stuffed     = 1'b0;
    phase_after = PH_IDLE;
    case (phase_r)
      PH_OPEN: begin
        phase_after = PH_DATA;
      end
      PH_DATA: begin
        cur_byte    = cur_r.data;
        stuffed     = 1'b1;
        phase_after = cur_r.last ? PH_CRC_LO : PH_IDLE;
      end
      PH_CRC_LO: begin
        cur_byte    = cur_r.crc[7:0];
        stuffed     = 1'b1;
        phase_after = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        cur_byte    = cur_r.crc[15:8];
        stuffed     = 1'b1;
        phase_after = PH_CLOSE;
      end
      PH_CLOSE: begin
        phase_after = PH_IDLE;
      end
      default: begin
        phase_after = PH_IDLE;
      end
    endcase
  end

  // Split a special byte into escape then flipped byte.
  always_comb begin
    if (stuffed && bsfe_pkg::needs_escape(cur_byte) && !esc_r) begin
      emit_byte = bsfe_pkg::ESC_BYTE;
      step_done = 1'b0;
    end else begin
      emit_byte = esc_r ? (cur_byte ^ bsfe_pkg::ESC_XOR) : cur_byte;
      step_done = 1'b1;
    end
  end

  assign finish = emit && step_done && (phase_after == PH_IDLE);
  assign q_pop  = q_valid && ((phase_r == PH_IDLE) || finish);

  always_comb begin
    phase_nxt = phase_r;
    if (q_pop) begin
      phase_nxt = q_head.first ? PH_OPEN : PH_DATA;
    end else if (emit && step_done) begin
      phase_nxt = phase_after;
    end
  end

  assign esc_nxt = emit ? (stuffed && bsfe_pkg::needs_escape(cur_byte) && !esc_r) : esc_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_byte;
      out_last_nxt  = finish;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      esc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      esc_r       <= esc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.line_byte = out_byte_r;
  assign out_if.run_last  = out_last_r;

  a_esc_phase: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> (phase_r == PH_DATA || phase_r == PH_CRC_LO || phase_r == PH_CRC_HI))
    else $error("escape pending outside a stuffed phase");

  a_esc_word: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(esc_r) |-> (out_valid_r && out_byte_r == bsfe_pkg::ESC_BYTE && !out_last_r))
    else $error("escape pending without an escape word on the output");

endmodule

`default_nettype wire

FILE: hdl/byte_stuffed_frame_encoder_top.sv
`default_nettype none

// Byte-stuffed frame encoder. Feed the body words of a frame (command,
// length, payload) on in_if with first_byte on the opening word and
// last_byte on the final one; line words come out on out_if. An opening
// word emits a 0x7E flag ahead of its data. Every body word is folded into
// a CRC-16 (poly 0x1021, init 0xFFFF, MSB first) and sent as is, or as
// 0x7D followed by the word XOR 0x20 when it equals 0x7E or 0x7D. The final
// word is followed by the CRC, low byte first and escaped the same way, and
// a closing 0x7E; the CRC then restarts from 0xFFFF. A word without a first
// mark after a frame closed continues with the restarted CRC and no flag.
// run_last marks the final line word caused by each input word. The front
// end computes the CRC in the accept cycle and queues the word
// (QUEUE_DEPTH entries); the emitter drains the queue and drives one line
// word per cycle while the output takes them, through an output register,
// so each input word gives its data word, or an escape pair, plus an opening
// flag when it opens and the CRC and closing flag when it is final.
// Sustained input rate is therefore set by the emitter's output. An input
// word passes through the queue, the emitter's word register and the output
// register before it reaches the line; the input keeps accepting while
// the queue has room, regardless of output backpressure.

module byte_stuffed_frame_encoder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bsfe_in_if.sink     in_if,
  bsfe_out_if.source  out_if
);

  logic             q_push;
  bsfe_pkg::entry_t q_push_entry;
  logic             q_not_full;
  logic             q_pop;
  logic             q_valid;
  bsfe_pkg::entry_t q_head;

  // Front end: take the word, run the CRC, queue the classified word.
  bsfe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .q_not_full (q_not_full),
    .push       (q_push),
    .push_entry (q_push_entry)
  );

  // Decouple front end from emitter so each can stall on its own.
  bsfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .not_full   (q_not_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (q_head)
  );

  // Emitter: flags, escapes and CRC bytes, one line word per cycle while the output takes them.
  bsfe_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule

`default_nettype wire

FILE: tb/byte_stuffed_frame_encoder_top_test.sv
`timescale 1ns / 100ps

module byte_stuffed_frame_encoder_top_test;

  // One body word as offered on the input channel.
  typedef struct {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } body_word_t;

  // One line word as it should appear on the result channel.
  typedef struct {
    logic [7:0] line_byte;
    logic       run_last;
  } line_word_t;

  logic clk = 1'b0;
  logic rst_n;

  bsfe_in_if  in_if ();
  bsfe_out_if out_if ();

  byte_stuffed_frame_encoder_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always #6 clk = ~clk;

  // Body words waiting to be offered, line words waiting to come out.
  body_word_t  body_pending[$];
  line_word_t  line_expect[$];
  logic [15:0] frame_crc;
  int          error_count;
  int          body_accepted;
  int          random_words;

  // ---------------------------------------------------------------------
  // Line predictor: frame CRC and byte stuffing, kept in step with the
  // block by feeding it every accepted body word.
  // ---------------------------------------------------------------------

  // CRC-16 with poly 0x1021, MSB first: shift the byte in bit by bit.
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    logic        fb;
    acc = crc;
    for (int bit_idx = 7; bit_idx >= 0; bit_idx--) begin
      fb  = acc[15] ^ b[bit_idx];
      acc = {acc[14:0], 1'b0};
      if (fb) begin
        acc = acc ^ bsfe_pkg::CRC_POLY;
      end
    end
    return acc;
  endfunction

  function automatic void expect_line(input logic [7:0] b);
    line_word_t w;
    w.line_byte = b;
    w.run_last  = 1'b0;
    line_expect.push_back(w);
  endfunction

  // Flag and escape bytes go out as an escape pair, all others as is.
  function automatic void expect_stuffed(input logic [7:0] b);
    if (b == bsfe_pkg::FLAG_BYTE || b == bsfe_pkg::ESC_BYTE) begin
      expect_line(bsfe_pkg::ESC_BYTE);
      expect_line(b ^ bsfe_pkg::ESC_XOR);
    end else begin
      expect_line(b);
    end
  endfunction

  function automatic void predict_line(input body_word_t w);
    // An opening word restarts the CRC and puts a flag on the line first.
    if (w.first_byte) begin
      frame_crc = bsfe_pkg::CRC_INIT;
      expect_line(bsfe_pkg::FLAG_BYTE);
    end
    frame_crc = crc16_update(frame_crc, w.data_byte);
    expect_stuffed(w.data_byte);
    // The closing word appends the CRC, low byte first, then the end flag.
    if (w.last_byte) begin
      expect_stuffed(frame_crc[7:0]);
      expect_stuffed(frame_crc[15:8]);
      expect_line(bsfe_pkg::FLAG_BYTE);
      frame_crc = bsfe_pkg::CRC_INIT;
    end
    line_expect[line_expect.size() - 1].run_last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic void queue_body(input logic [7:0] b, input logic f, input logic l);
    body_word_t w;
    w.data_byte  = b;
    w.first_byte = f;
    w.last_byte  = l;
    body_pending.push_back(w);
  endfunction

  // Bias payload toward the two bytes that need stuffing.
  function automatic logic [7:0] pick_body_byte();
    case ($urandom_range(0, 7))
      0: return bsfe_pkg::FLAG_BYTE;
      1: return bsfe_pkg::ESC_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Driver: bursts of random length separated by random gaps.
  // ---------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid      <= 1'b0;
      in_if.data_byte  <= 8'h00;
      in_if.first_byte <= 1'b0;
      in_if.last_byte  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      // Predict the word the block takes at this edge.
      if (in_if.valid && in_if.ready) begin
        predict_line('{in_if.data_byte, in_if.first_byte, in_if.last_byte});
        body_accepted++;
      end
      // Advance only when nothing is on offer or the offer was taken.
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0 || body_pending.size() == 0) begin
          in_if.valid <= 1'b0;
          if (gap_left > 0) begin
            gap_left--;
          end
        end else begin
          body_word_t w;
          w = body_pending.pop_front();
          in_if.valid      <= 1'b1;
          in_if.data_byte  <= w.data_byte;
          in_if.first_byte <= w.first_byte;
          in_if.last_byte  <= w.last_byte;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // Some bursts are long and some get no gap, for stretches at full rate.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: rotating stall pattern, plus one long hold-off mid-run so
  // the block's queue fills and it pushes back on the input.
  // ---------------------------------------------------------------------
  logic [7:0] stall_pattern;
  int         pattern_age;
  int         hold_left;
  logic       hold_done;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready  <= 1'b0;
      stall_pattern = 8'hFF;
      pattern_age   = 0;
      hold_left     = 0;
      hold_done     = 1'b0;
    end else begin
      if (!hold_done && body_accepted >= 80) begin
        hold_done = 1'b1;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        pattern_age++;
        if (pattern_age >= 48) begin
          pattern_age   = 0;
          // Now and then drop stalls entirely for a stretch.
          stall_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF
                                                      : 8'($urandom_range(1, 255));
        end
        stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
        out_if.ready <= stall_pattern[0];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: compare each line word with the oldest prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (line_expect.size() == 0) begin
        $error("unexpected line word: line_byte=%02h run_last=%0b",
               out_if.line_byte, out_if.run_last);
        error_count++;
      end else begin
        line_word_t exp_w;
        exp_w = line_expect.pop_front();
        if (out_if.line_byte !== exp_w.line_byte) begin
          $error("line_byte: expected %02h, got %02h", exp_w.line_byte, out_if.line_byte);
          error_count++;
        end
        if (out_if.run_last !== exp_w.run_last) begin
          $error("run_last: expected %0b, got %0b", exp_w.run_last, out_if.run_last);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int         frame_kind;
    int         payload_len;
    logic [15:0] probe_crc;
    logic       found_lo;
    logic       found_hi;

    in_if.valid      = 1'b0;
    in_if.data_byte  = 8'h00;
    in_if.first_byte = 1'b0;
    in_if.last_byte  = 1'b0;
    out_if.ready     = 1'b0;
    frame_crc        = bsfe_pkg::CRC_INIT;
    error_count      = 0;
    body_accepted    = 0;
    random_words     = 0;
    rst_n            = 1'b0;

    // Stray word right after reset: no flag, CRC from its start value.
    queue_body(8'h11, 1'b0, 1'b0);
    // Stray closing word that needs stuffing, without an opening mark.
    queue_body(bsfe_pkg::FLAG_BYTE, 1'b0, 1'b1);
    // One-word frames at the byte extremes and on both stuffed values.
    queue_body(8'h00, 1'b1, 1'b1);
    queue_body(8'hFF, 1'b1, 1'b1);
    queue_body(bsfe_pkg::FLAG_BYTE, 1'b1, 1'b1);
    queue_body(bsfe_pkg::ESC_BYTE, 1'b1, 1'b1);
    // Full frame with stuffed command and payload; length is not checked.
    queue_body(bsfe_pkg::ESC_BYTE, 1'b1, 1'b0);
    queue_body(8'h04, 1'b0, 1'b0);
    queue_body(bsfe_pkg::FLAG_BYTE, 1'b0, 1'b0);
    queue_body(8'h5E, 1'b0, 1'b0);
    queue_body(8'h5D, 1'b0, 1'b0);
    queue_body(8'hFF, 1'b0, 1'b1);
    // Frame reopened before it closed: the new opening restarts the CRC.
    queue_body(8'h01, 1'b1, 1'b0);
    queue_body(8'h02, 1'b0, 1'b0);
    queue_body(8'h03, 1'b1, 1'b0);
    queue_body(bsfe_pkg::ESC_BYTE, 1'b0, 1'b1);
    // One-word frames whose CRC low or high byte needs stuffing.
    found_lo = 1'b0;
    found_hi = 1'b0;
    for (int b = 0; b < 256; b++) begin
      probe_crc = crc16_update(bsfe_pkg::CRC_INIT, 8'(b));
      if (!found_lo && (probe_crc[7:0] == bsfe_pkg::FLAG_BYTE ||
                        probe_crc[7:0] == bsfe_pkg::ESC_BYTE)) begin
        found_lo = 1'b1;
        queue_body(8'(b), 1'b1, 1'b1);
      end else if (!found_hi && (probe_crc[15:8] == bsfe_pkg::FLAG_BYTE ||
                                 probe_crc[15:8] == bsfe_pkg::ESC_BYTE)) begin
        found_hi = 1'b1;
        queue_body(8'(b), 1'b1, 1'b1);
      end
    end

    // Random part: mostly well-formed frames, some noise and cut frames.
    while (random_words < 210) begin
      frame_kind = $urandom_range(0, 9);
      if (frame_kind == 0) begin
        queue_body(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
        random_words++;
      end else begin
        payload_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20)
                                                  : $urandom_range(0, 8);
        queue_body(pick_body_byte(), 1'b1, 1'b0);
        // Length word closes the frame when there is no payload, unless the frame is cut.
        queue_body(8'(payload_len), 1'b0, (payload_len == 0) && (frame_kind != 1));
        for (int i = 0; i < payload_len; i++) begin
          // A cut frame never gets its closing mark.
          queue_body(pick_body_byte(), 1'b0, (i == payload_len - 1) && (frame_kind != 1));
        end
        random_words += payload_len + 2;
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all words offered and taken, then all line words seen.
    while (body_pending.size() != 0 || in_if.valid) @(posedge clk);
    while (line_expect.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #2400000;
    $display("Some tests failed");
    $finish;
  end

endmodule
